### hw/rtl/fsmet_pkg.sv
// shared widths, constants and the square root step for the segment metrics core
package fsmet_pkg;

   localparam int REQ_W    = 176;
   localparam int RSP_W    = 120;
   localparam int COORD_W  = 24;
   localparam int RAD_W    = 16;
   localparam int AXIS_W   = 25;
   localparam int AREA_W   = 40;
   localparam int VOL_W    = 48;
   localparam int SQ_STEPS = 26;
   localparam int SQ_RAD_W = 2 * SQ_STEPS;
   localparam int SQ_REM_W = SQ_STEPS + 2;

   localparam logic [33:0] PI_Q32  = 34'd13493037705;
   localparam logic [32:0] PI3_Q32 = 33'd4497679235;

   typedef struct packed {
      logic [SQ_RAD_W-1:0] rad;
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_STEPS-1:0] root;
   } sq_state_type;

   function automatic sq_state_type sq_step(sq_state_type s);
      sq_state_type n;
      logic [SQ_REM_W+1:0] cur;
      logic [SQ_REM_W+1:0] trial;
      cur   = {s.rem, s.rad[SQ_RAD_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      n.rad = {s.rad[SQ_RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         n.rem  = SQ_REM_W'(cur - trial);
         n.root = {s.root[SQ_STEPS-2:0], 1'b1};
      end else begin
         n.rem  = cur[SQ_REM_W-1:0];
         n.root = {s.root[SQ_STEPS-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

### hw/rtl/frustum_segment_metrics_core.sv
// truncated cone segment metrics: axis length, surface area and volume
//
//  channel | dir | payload
//  req_    | in  | two points: x, y, z (24b signed) and radius (16b), q8
//  rsp_    | out | axis length (25b), surface area (40b), volume (48b), q8
//
// one beat per cycle sustained while rsp is not stalled
// most of the pipe depth comes from the two bit-serial square roots, one result bit per stage
// reset clears only the stage valid bits
// a stall on rsp freezes the whole pipe and drops req_tready in the same cycle
module frustum_segment_metrics_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
   // second_radius
   input  logic [fsmet_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // axis_length, surface_area, frustum_volume, zero pad
   output logic [fsmet_pkg::RSP_W-1:0] rsp_tdata
);
   import fsmet_pkg::*;

   localparam int NSTG = SQ_STEPS + 7;

   logic            advance;
   logic [NSTG-1:0] valid_ff;

   // stage 1
   logic [COORD_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [RAD_W-1:0]   r1_ff, r2_ff, dr_ff;
   logic [RAD_W:0]     rs1_ff;
   logic [COORD_W:0]   dx_in, dy_in, dz_in;
   // stage 2
   logic [2*COORD_W-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic [2*RAD_W-1:0]   dr2_ff, r1sq_ff, r2sq_ff, r12_ff;
   logic [RAD_W:0]       rs2_ff;
   // stage 3 and square root stages
   logic [2*COORD_W+1:0] d2_in;
   sq_state_type         len_sq_ff [0:SQ_STEPS];
   sq_state_type         sl_sq_ff  [0:SQ_STEPS];
   logic [RAD_W:0]       rs_sq_ff  [0:SQ_STEPS];
   logic [2*RAD_W:0]     ssum_sq_ff[0:SQ_STEPS];
   logic [2*RAD_W+1:0]   tsum_sq_ff[0:SQ_STEPS];
   // post stages
   logic [AXIS_W-1:0] len_a_ff, len_b_ff, len_c_ff, len_d_ff;
   logic [42:0]       as_ff;
   logic [2*RAD_W:0]  ssum_a_ff;
   logic [58:0]       lt_ff;
   logic [43:0]       asum_ff;
   logic [52:0]       vp0_ff, vp1_ff;
   logic [51:0]       vp2_ff;
   logic [55:0]       ap0_ff, ap1_ff;
   logic [VOL_W-1:0]  vol_c_ff, vol_d_ff;
   logic [AREA_W-1:0] area_d_ff;
   logic [95:0]       v_in;
   logic [79:0]       a_in;

   function automatic logic [COORD_W:0] sdiff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      sdiff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
   endfunction

   assign advance    = !valid_ff[NSTG-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[NSTG-1];
   assign rsp_tdata  = {7'd0, vol_d_ff, area_d_ff, len_d_ff};

   assign dx_in = sdiff(req_tdata[23:0],  req_tdata[111:88]);
   assign dy_in = sdiff(req_tdata[47:24], req_tdata[135:112]);
   assign dz_in = sdiff(req_tdata[71:48], req_tdata[159:136]);
   assign d2_in = {2'b00, dx2_ff} + {2'b00, dy2_ff} + {2'b00, dz2_ff};
   assign v_in  = {43'd0, vp0_ff} + {23'd0, vp1_ff, 20'd0} + {4'd0, vp2_ff, 40'd0};
   assign a_in  = {24'd0, ap0_ff} + {2'd0, ap1_ff, 22'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NSTG-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff  <= dx_in[COORD_W] ? COORD_W'(-dx_in) : dx_in[COORD_W-1:0];
         dy_ff  <= dy_in[COORD_W] ? COORD_W'(-dy_in) : dy_in[COORD_W-1:0];
         dz_ff  <= dz_in[COORD_W] ? COORD_W'(-dz_in) : dz_in[COORD_W-1:0];
         r1_ff  <= req_tdata[87:72];
         r2_ff  <= req_tdata[175:160];
         dr_ff  <= (req_tdata[87:72] > req_tdata[175:160]) ?
                   req_tdata[87:72] - req_tdata[175:160] :
                   req_tdata[175:160] - req_tdata[87:72];
         rs1_ff <= {1'b0, req_tdata[87:72]} + {1'b0, req_tdata[175:160]};

         dx2_ff  <= dx_ff * dx_ff;
         dy2_ff  <= dy_ff * dy_ff;
         dz2_ff  <= dz_ff * dz_ff;
         dr2_ff  <= dr_ff * dr_ff;
         r1sq_ff <= r1_ff * r1_ff;
         r2sq_ff <= r2_ff * r2_ff;
         r12_ff  <= r1_ff * r2_ff;
         rs2_ff  <= rs1_ff;

         len_sq_ff[0]  <= '{rad: {2'b00, d2_in}, rem: '0, root: '0};
         sl_sq_ff[0]   <= '{rad: SQ_RAD_W'(d2_in) + SQ_RAD_W'(dr2_ff), rem: '0, root: '0};
         rs_sq_ff[0]   <= rs2_ff;
         ssum_sq_ff[0] <= {1'b0, r1sq_ff} + {1'b0, r2sq_ff};
         tsum_sq_ff[0] <= {2'b00, r1sq_ff} + {2'b00, r12_ff} + {2'b00, r2sq_ff};

         for (int j = 0; j < SQ_STEPS; j++) begin
            len_sq_ff[j+1]  <= sq_step(len_sq_ff[j]);
            sl_sq_ff[j+1]   <= sq_step(sl_sq_ff[j]);
            rs_sq_ff[j+1]   <= rs_sq_ff[j];
            ssum_sq_ff[j+1] <= ssum_sq_ff[j];
            tsum_sq_ff[j+1] <= tsum_sq_ff[j];
         end

         len_a_ff  <= len_sq_ff[SQ_STEPS].root[AXIS_W-1:0];
         as_ff     <= rs_sq_ff[SQ_STEPS] * sl_sq_ff[SQ_STEPS].root;
         lt_ff     <= len_sq_ff[SQ_STEPS].root[AXIS_W-1:0] * tsum_sq_ff[SQ_STEPS];
         ssum_a_ff <= ssum_sq_ff[SQ_STEPS];

         len_b_ff <= len_a_ff;
         asum_ff  <= {1'b0, as_ff} + {11'd0, ssum_a_ff};
         vp0_ff   <= lt_ff[19:0] * PI3_Q32;
         vp1_ff   <= lt_ff[39:20] * PI3_Q32;
         vp2_ff   <= lt_ff[58:40] * PI3_Q32;

         len_c_ff <= len_b_ff;
         ap0_ff   <= asum_ff[21:0] * PI_Q32;
         ap1_ff   <= asum_ff[43:22] * PI_Q32;
         vol_c_ff <= v_in[95:48];

         len_d_ff  <= len_c_ff;
         area_d_ff <= a_in[79:40];
         vol_d_ff  <= vol_c_ff;
      end
   end

endmodule
